// ===== sv/idpa_pkg.sv =====
// Shared types, constants and helpers for the id pool allocator.
package idpa_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ID_W        = $clog2(MAX_ENTRIES + 1);
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [SLOT_W-1:0] slot;
  } idpa_cmd_t;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(MAX_ENTRIES - 1)) ? '0 : SLOT_W'(p + SLOT_W'(1));
  endfunction

endpackage

// ===== sv/idpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module idpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/idpa_front.sv =====
// Command intake: range check and decode of each beat, then a short command queue.
module idpa_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [idpa_pkg::CMD_W-1:0]   command_i,
  input  logic [idpa_pkg::ID_W-1:0]    entry_id_i,
  output logic                         q_valid_o,
  output idpa_pkg::idpa_cmd_t          q_entry_o,
  input  logic                         q_pop_i
);
  import idpa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  idpa_cmd_t         entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  idpa_cmd_t         cls;
  logic              id_ok, push, pop;

  assign id_ok = (entry_id_i != '0) && (entry_id_i <= ID_W'(MAX_ENTRIES));

  always_comb begin
    cls.id   = entry_id_i;
    cls.slot = SLOT_W'(entry_id_i - ID_W'(1));
    unique case (command_i)
      CMD_ALLOC: cls.op = OP_ALLOC;
      CMD_FREE:  cls.op = id_ok ? OP_FREE : OP_REJECT;
      CMD_QUERY: cls.op = id_ok ? OP_QUERY : OP_REJECT;
      default:   cls.op = OP_REJECT;
    endcase
  end

  assign in_stall_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && (cnt_q != '0);
  assign q_valid_o  = (cnt_q != '0);
  assign q_entry_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + PTR_W'(1));
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + PTR_W'(1));
    end
    if (push && !pop) begin
      cnt_d = QCNT_W'(cnt_q + QCNT_W'(1));
    end else if (pop && !push) begin
      cnt_d = QCNT_W'(cnt_q - QCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== sv/idpa_back.sv =====
// Command execution: free-list ring, high-water counter, allocation bitmap, result register.
module idpa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [idpa_pkg::ID_W-1:0]     pool_size_i,
  input  logic                          q_valid_i,
  input  idpa_pkg::idpa_cmd_t           q_entry_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [idpa_pkg::STATUS_W-1:0] status_o,
  output logic [idpa_pkg::ID_W-1:0]     result_id_o,
  output logic [idpa_pkg::SLOT_W-1:0]   slot_index_o
);
  import idpa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_q, state_d;
  idpa_cmd_t         cur_q;
  logic [ID_W-1:0]   fresh_q, fresh_d;
  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              out_valid_q;
  status_e           status_q;
  logic [ID_W-1:0]   result_id_q;
  logic [SLOT_W-1:0] slot_q;

  logic              map_we, map_wdata, map_rdata;
  logic [SLOT_W-1:0] map_waddr;
  logic              fl_we;
  logic [ID_W-1:0]   fl_rdata;
  logic              rd_en, out_free, load, held;
  logic [ID_W-1:0]   eff_size, res_id;
  status_e           res_status;

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign rd_en    = q_pop_o;
  assign load     = (state_q == S_EXEC) && out_free;
  assign eff_size = (pool_size_i > ID_W'(MAX_ENTRIES)) ? ID_W'(MAX_ENTRIES) : pool_size_i;
  // Ids at or above the high-water mark were never written into the bitmap.
  assign held     = (cur_q.id < fresh_q) && map_rdata;

  idpa_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (map_we),
    .wr_addr_i (map_waddr),
    .wr_data_i (map_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (q_entry_i.slot),
    .rd_data_o (map_rdata)
  );

  idpa_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_free_list (
    .clk_i     (clk_i),
    .wr_en_i   (fl_we),
    .wr_addr_i (tail_q),
    .wr_data_i (cur_q.id),
    .rd_en_i   (rd_en),
    .rd_addr_i (head_q),
    .rd_data_o (fl_rdata)
  );

  always_comb begin
    state_d    = state_q;
    fresh_d    = fresh_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    map_we     = 1'b0;
    map_waddr  = cur_q.slot;
    map_wdata  = 1'b0;
    fl_we      = 1'b0;
    res_status = ST_BAD;
    res_id     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cur_q.op)
          OP_ALLOC: begin
            if (count_q != '0) begin
              res_status = ST_OK;
              res_id     = fl_rdata;
              head_d     = ring_next(head_q);
              count_d    = CNT_W'(count_q - CNT_W'(1));
            end else if (fresh_q > eff_size) begin
              res_status = ST_FULL;
            end else begin
              res_status = ST_OK;
              res_id     = fresh_q;
              fresh_d    = ID_W'(fresh_q + ID_W'(1));
            end
            map_waddr = SLOT_W'(res_id - ID_W'(1));
            map_wdata = 1'b1;
            map_we    = load && (res_status == ST_OK);
          end
          OP_FREE: begin
            if (held && (count_q < CNT_W'(MAX_ENTRIES))) begin
              res_status = ST_OK;
              res_id     = cur_q.id;
              map_we     = load;
              fl_we      = load;
              tail_d     = ring_next(tail_q);
              count_d    = CNT_W'(count_q + CNT_W'(1));
            end
          end
          OP_QUERY: begin
            if (held) begin
              res_status = ST_OK;
              res_id     = cur_q.id;
            end
          end
          default: begin
            res_status = ST_BAD;
          end
        endcase
        if (!load) begin
          fresh_d = fresh_q;
          head_d  = head_q;
          tail_d  = tail_q;
          count_d = count_q;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fresh_q     <= ID_W'(1);
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fresh_q <= fresh_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
    if (load) begin
      status_q    <= res_status;
      result_id_q <= res_id;
      slot_q      <= (res_status == ST_OK) ? SLOT_W'(res_id - ID_W'(1)) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign result_id_o  = result_id_q;
  assign slot_index_o = slot_q;

endmodule

// ===== sv/id_pool_allocator.sv =====
// Top level of the id pool allocator: config register, intake, execution and checks.
// Hands out fresh ids 1..pool_size, capped at MAX_ENTRIES, and reuses freed ids oldest
// first. Each command beat passes a two-entry queue and then the execution stage: the
// idle state pops it and issues the registered reads of the allocation bitmap and the
// free-list RAM, and the exec state decides, writes back and loads the result register,
// waiting there while the result register still holds a stalled beat. A new command is
// taken only after the current one has loaded its result. No clearing pass follows reset: bitmap
// entries at or above the fresh-id counter read as not allocated. pool_size may only
// be written while no command is in flight.
module id_pool_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [idpa_pkg::ID_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [idpa_pkg::CMD_W-1:0]    command_i,
  input  logic [idpa_pkg::ID_W-1:0]     entry_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [idpa_pkg::STATUS_W-1:0] status_o,
  output logic [idpa_pkg::ID_W-1:0]     result_id_o,
  output logic [idpa_pkg::SLOT_W-1:0]   slot_index_o
);
  import idpa_pkg::*;

  logic [ID_W-1:0] pool_size_q;
  logic            q_valid, q_pop;
  idpa_cmd_t       q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= ID_W'(1024);
    end else if (cfg_we_i) begin
      pool_size_q <= cfg_wdata_i;
    end
  end

  idpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .entry_id_i (entry_id_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  idpa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pool_size_i  (pool_size_q),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .result_id_o  (result_id_o),
    .slot_index_o (slot_index_o)
  );

  a_ok_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |->
      (result_id_o != '0) && (slot_index_o == SLOT_W'(result_id_o - ID_W'(1))))
    else $error("ok beat with inconsistent id and slot");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (result_id_o == '0) && (slot_index_o == '0))
    else $error("error beat carries an id");

  a_stall_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_valid)
    else $error("intake stalls with an empty queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop)
    else $error("back end took two commands in consecutive cycles");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the id pool allocator: directed and random command beats checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import idpa_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_IDS = 100;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    status_e             status;
    logic [ID_W-1:0]     rid;
    logic [SLOT_W-1:0]   slot;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [ID_W-1:0]     cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic [CMD_W-1:0]    command = '0;
  logic [ID_W-1:0]     entry_id = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [ID_W-1:0]     rsp_id;
  logic [SLOT_W-1:0]   rsp_slot;

  // predictor state
  logic [ID_W-1:0]     pool_sz = ID_W'(MAX_ENTRIES);
  logic [ID_W-1:0]     next_fresh = ID_W'(1);
  logic [ID_W-1:0]     fl_ring [MAX_ENTRIES];
  logic [SLOT_W-1:0]   fl_head = '0;
  logic [SLOT_W-1:0]   fl_tail = '0;
  logic [CNT_W-1:0]    fl_count = '0;
  bit                  held_map [MAX_ENTRIES];
  reply_t              reply_q [$];

  int                  errors = 0;
  int                  cycles = 0;
  bit                  src_idle_en = 1'b1;
  bit                  snk_idle_en = 1'b1;
  int                  hold_reqs = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;

  id_pool_allocator dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .entry_id_i   (entry_id),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (rsp_status),
    .result_id_o  (rsp_id),
    .slot_index_o (rsp_slot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [SLOT_W-1:0] ring_step(input logic [SLOT_W-1:0] p);
    return (p == SLOT_W'(MAX_ENTRIES - 1)) ? '0 : SLOT_W'(p + 1'b1);
  endfunction

  function automatic bit is_held(input logic [ID_W-1:0] id);
    return (id != 0) && (id <= MAX_ENTRIES) && held_map[id - 1];
  endfunction

  function automatic void predict_reply(input logic [CMD_W-1:0] cmd,
                                        input logic [ID_W-1:0] id);
    reply_t          r;
    logic [ID_W-1:0] got;
    int              eff;
    eff = (pool_sz > MAX_ENTRIES) ? MAX_ENTRIES : int'(pool_sz);
    r.status = ST_BAD;
    got = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (fl_count != 0) begin
          got = fl_ring[fl_head];
          fl_head = ring_step(fl_head);
          fl_count = fl_count - 1'b1;
          r.status = ST_OK;
        end else if (int'(next_fresh) > eff) begin
          r.status = ST_FULL;
        end else begin
          got = next_fresh;
          next_fresh = next_fresh + 1'b1;
          r.status = ST_OK;
        end
        if (r.status == ST_OK && got >= 1 && got <= MAX_ENTRIES) held_map[got - 1] = 1'b1;
      end
      CMD_FREE: begin
        if (is_held(id) && fl_count < MAX_ENTRIES) begin
          held_map[id - 1] = 1'b0;
          fl_ring[fl_tail] = id;
          fl_tail = ring_step(fl_tail);
          fl_count = fl_count + 1'b1;
          got = id;
          r.status = ST_OK;
        end
      end
      CMD_QUERY: begin
        if (is_held(id)) begin
          got = id;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.rid = got;
    r.slot = (got == 0) ? '0 : SLOT_W'(got - 1'b1);
    reply_q = {reply_q, r};
  endfunction

  // one command beat; prediction is taken at the accepting edge
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    while (src_idle_en && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    entry_id <= id;
    do @(posedge clk); while (in_stall);
    predict_reply(cmd, id);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pool(input logic [ID_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pool_sz = v;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_held_id();
    logic [ID_W-1:0] c;
    int              top;
    top = int'(next_fresh) - 1;
    if (top < 1) return ID_W'(1);
    c = ID_W'(1);
    repeat (8) begin
      c = ID_W'($urandom_range(1, top));
      if (held_map[c - 1]) return c;
    end
    return c;
  endfunction

  task automatic random_mix(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) send_cmd(CMD_ALLOC, ID_W'($urandom));
      else if (r < 70) send_cmd(CMD_FREE, pick_held_id());
      else if (r < 85) send_cmd(CMD_QUERY, pick_held_id());
      else if (r < 95) send_cmd(($urandom_range(1) != 0) ? CMD_FREE : CMD_QUERY,
                                ($urandom_range(3) == 0) ? '0 : ID_W'($urandom));
      else send_cmd(CMD_UNUSED, ID_W'($urandom));
    end
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= snk_idle_en && ($urandom_range(99) < 20);
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        $error("reply with none pending: status %0d id %0d slot %0d",
               rsp_status, rsp_id, rsp_slot);
        errors++;
      end else begin
        e = reply_q.pop_front();
        if (rsp_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_status);
          errors++;
        end
        if (rsp_id !== e.rid) begin
          $error("result_id: expected %0d, got %0d", e.rid, rsp_id);
          errors++;
        end
        if (rsp_slot !== e.slot) begin
          $error("slot_index: expected %0d, got %0d", e.slot, rsp_slot);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_QUERY, ID_W'(1));
    send_cmd(CMD_FREE, '0);
    send_cmd(CMD_FREE, ID_W'(2047));
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_QUERY, ID_W'(1025));
    send_cmd(CMD_UNUSED, ID_W'(2047));
    send_cmd(CMD_FREE, ID_W'(1));
    send_cmd(CMD_FREE, ID_W'(1));
    send_cmd(CMD_QUERY, ID_W'(1));
    send_cmd(CMD_ALLOC, ID_W'(2047));
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_QUERY, ID_W'(1024));
    send_cmd(CMD_FREE, ID_W'(3));
    set_pool('0);
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_FREE, ID_W'(2));
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, '0);
    set_pool(ID_W'(1));
    send_cmd(CMD_ALLOC, '0);
    set_pool(ID_W'(3));
    send_cmd(CMD_ALLOC, '0);
    send_cmd(CMD_ALLOC, '0);
    wait_drained();
  endtask

  task automatic test_small_pools();
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(3) == 0) set_pool(ID_W'($urandom_range(0, 2)));
      else set_pool(next_fresh + ID_W'($urandom_range(0, 12)));
      random_mix(35);
    end
    wait_drained();
  endtask

  task automatic test_no_idle();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    set_pool(next_fresh + ID_W'(20));
    random_mix(120);
    wait_drained();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    random_mix(40);
    wait_drained();
  endtask

  task automatic test_fill();
    set_pool(ID_W'(2047));
    while (next_fresh <= MAX_ENTRIES) begin
      if ($urandom_range(9) == 0) send_cmd(CMD_QUERY, pick_held_id());
      else send_cmd(CMD_ALLOC, ID_W'($urandom));
    end
    repeat (4) send_cmd(CMD_ALLOC, '0);
    set_pool(ID_W'(MAX_ENTRIES));
    send_cmd(CMD_QUERY, ID_W'(MAX_ENTRIES));
    send_cmd(CMD_ALLOC, '0);
    wait_drained();
  endtask

  task automatic test_drain();
    logic [ID_W-1:0] ids [$];
    logic [ID_W-1:0] t;
    int              j;
    for (int i = 1; i <= MAX_ENTRIES; i++) begin
      if (held_map[i - 1]) ids = {ids, ID_W'(i)};
    end
    for (int i = ids.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = ids[i];
      ids[i] = ids[j];
      ids[j] = t;
    end
    for (int i = 0; (i < ids.size()) && (i < DRAIN_IDS); i++) begin
      send_cmd(CMD_FREE, ids[i]);
      if ($urandom_range(19) == 0) send_cmd(CMD_QUERY, ids[i]);
      if ($urandom_range(29) == 0) send_cmd(CMD_FREE, ids[i]);
    end
    // lowered size: ids on the free list keep coming back
    set_pool(ID_W'(100));
    random_mix(50);
    wait_drained();
  endtask

  task automatic test_recycle();
    set_pool('0);
    while (fl_count != 0) begin
      if ($urandom_range(9) == 0) send_cmd(CMD_FREE, pick_held_id());
      else send_cmd(CMD_ALLOC, ID_W'($urandom));
    end
    repeat (3) send_cmd(CMD_ALLOC, '0);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_small_pools();
    test_no_idle();
    test_backpressure();
    test_fill();
    test_drain();
    test_recycle();
    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/idpa_pkg.sv
sv/idpa_ram.sv
sv/idpa_front.sv
sv/idpa_back.sv
sv/id_pool_allocator.sv
tb/sv/tb_top.sv
